// ===== src/deq_pkg.sv =====
`timescale 1ns / 1ps

package deq_pkg;

    // Default sizing of the element store
    localparam int DEF_DEPTH      = 1024;
    localparam int DEF_DATA_WIDTH = 32;

    // Fixed port widths
    localparam int REQ_W     = 3;
    localparam int VAL_W     = 32;
    localparam int POS_W     = 11;
    localparam int CNT_OUT_W = 11;
    localparam int STAT_W    = 2;

    // Step counter for the bit-serial remainder unit
    localparam int STEP_W = $clog2(POS_W + 1);

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_FRONT = 3'd0,
        REQ_PUSH_BACK  = 3'd1,
        REQ_POP_FRONT  = 3'd2,
        REQ_POP_BACK   = 3'd3,
        REQ_READ       = 3'd4,
        REQ_CLEAR      = 3'd5
    } t_req;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_IDX,
        S_RD,
        S_OUT
    } t_state;

endpackage

// ===== src/double_ended_queue.sv =====
`timescale 1ns / 1ps

// Bounded double-ended queue kept as a ring in a single-port-write, single-port-read
// RAM of DEPTH entries. Push front/back, pop front/back, clear, and unknown request
// codes finish in the cycle they are accepted, with the result registered on the
// next edge, so these can be issued every cycle while the result side keeps up. An
// indexed read of a non-empty queue reduces the signed position modulo the element
// count in a one-bit-per-cycle remainder unit (11 steps for the 11-bit position),
// then forms the ring address, reads the RAM and registers the result, with the
// input held off until that result is registered and the result side is free, so a
// new read is not taken before the last one is through. A read of an empty queue
// returns status empty at once. Pushes onto a full queue are dropped with status
// full. The input is not ready while reset is held. Entries are undefined until
// pushed, and only pushed entries can ever be read.
module double_ended_queue #(
    parameter int DEPTH      = deq_pkg::DEF_DEPTH,
    parameter int DATA_WIDTH = deq_pkg::DEF_DATA_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Request channel
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [deq_pkg::REQ_W-1:0]      i_req_type,
    input  logic [deq_pkg::VAL_W-1:0]      i_push_value,
    input  logic signed [deq_pkg::POS_W-1:0] i_position,
    // Result channel
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [deq_pkg::VAL_W-1:0]      o_read_value,
    output logic [deq_pkg::CNT_OUT_W-1:0]  o_element_count,
    output logic                           o_is_empty,
    output logic [deq_pkg::STAT_W-1:0]     o_status
);

    import deq_pkg::*;

    localparam int SW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [SW:0]   DEPTH_S = (SW + 1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [SW-1:0] LAST_SLOT = SW'(DEPTH - 1);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(POS_W - 1);

    // Control and queue state
    t_state r_state, n_state;
    logic [SW-1:0] r_front, n_front;
    logic [CW-1:0] r_count, n_count;
    logic          r_out_valid, n_out_valid;

    // Remainder unit
    logic [POS_W-1:0]  r_dvd, n_dvd;
    logic [CW-1:0]     r_rem, n_rem;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_neg, n_neg;
    logic [SW-1:0]     r_addr, n_addr;

    // Result payload
    logic [VAL_W-1:0]     r_rd_value, n_rd_value;
    logic [CNT_OUT_W-1:0] r_cnt_out, n_cnt_out;
    logic                 r_empty_out, n_empty_out;
    t_status              r_status, n_status;

    // RAM interface
    logic                  ram_we;
    logic [SW-1:0]         ram_waddr;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic                  ram_re;
    logic [DATA_WIDTH-1:0] ram_rdata;

    logic          accept;
    logic          out_free;
    logic          is_full;
    logic          is_none;
    t_req          req;
    logic [SW:0]   back_sum;
    logic [SW-1:0] back_slot;
    logic [SW:0]   next_sum;
    logic [SW-1:0] next_slot;
    logic [SW-1:0] prev_slot;
    logic [CW:0]   div_trial;
    logic [CW-1:0] idx;
    logic [SW:0]   idx_sum;
    logic [POS_W-1:0] pos_raw;
    logic [POS_W-1:0] pos_mag;
    logic [VAL_W+DATA_WIDTH-1:0] wdata_ext;
    logic [DATA_WIDTH+VAL_W-1:0] rdata_ext;
    logic [CW+CNT_OUT_W-1:0]     cnt_ext;

    deq_ram #(
        .WIDTH(DATA_WIDTH),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    assign out_free = !r_out_valid || i_ready;
    assign accept   = i_valid && o_ready;
    assign is_full  = (r_count == DEPTH_C);
    assign is_none  = (r_count == '0);
    assign req      = t_req'(i_req_type);
    assign pos_raw  = i_position;
    assign pos_mag  = pos_raw[POS_W-1] ? (~pos_raw + POS_W'(1)) : pos_raw;

    // Ring slot arithmetic: back slot, slot after front, slot before front
    assign back_sum  = {1'b0, r_front} + (SW + 1)'(r_count);
    assign back_slot = (back_sum >= DEPTH_S) ? SW'(back_sum - DEPTH_S) : back_sum[SW-1:0];
    assign next_sum  = {1'b0, r_front} + (SW + 1)'(1);
    assign next_slot = (next_sum >= DEPTH_S) ? SW'(next_sum - DEPTH_S) : next_sum[SW-1:0];
    assign prev_slot = (r_front == '0) ? LAST_SLOT : r_front - SW'(1);

    // One restoring remainder step
    assign div_trial = {r_rem, r_dvd[POS_W-1]};

    // Fold a negative position back to the front and add to the front slot
    assign idx     = (r_neg && r_rem != '0) ? r_count - r_rem : (r_neg ? '0 : r_rem);
    assign idx_sum = {1'b0, r_front} + (SW + 1)'(idx);

    // Fit push data and read data to the store width
    assign wdata_ext = {{DATA_WIDTH{1'b0}}, i_push_value};
    assign ram_wdata = wdata_ext[DATA_WIDTH-1:0];
    assign rdata_ext = {{VAL_W{1'b0}}, ram_rdata};

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && req == REQ_READ && !is_none) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (r_step == LAST_STEP) begin
                    n_state = S_IDX;
                end
            end
            S_IDX:   n_state = S_RD;
            S_RD:    n_state = S_OUT;
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        o_ready = 1'b0;
        ram_re  = 1'b0;
        case (r_state)
            S_IDLE:  o_ready = out_free && i_rst_n;
            S_RD:    ram_re  = 1'b1;
            default: ;
        endcase
    end

    // Datapath next values
    always_comb begin
        n_front     = r_front;
        n_count     = r_count;
        n_out_valid = r_out_valid && !i_ready;
        n_dvd       = r_dvd;
        n_rem       = r_rem;
        n_step      = r_step;
        n_neg       = r_neg;
        n_addr      = r_addr;
        n_rd_value  = r_rd_value;
        n_status    = r_status;
        ram_we      = 1'b0;
        ram_waddr   = back_slot;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_status   = ST_OK;
                    n_rd_value = '0;
                    case (req)
                        REQ_PUSH_FRONT: begin
                            if (is_full) begin
                                n_status = ST_FULL;
                            end else begin
                                n_front   = prev_slot;
                                n_count   = r_count + CW'(1);
                                ram_we    = 1'b1;
                                ram_waddr = prev_slot;
                            end
                        end
                        REQ_PUSH_BACK: begin
                            if (is_full) begin
                                n_status = ST_FULL;
                            end else begin
                                n_count = r_count + CW'(1);
                                ram_we  = 1'b1;
                            end
                        end
                        REQ_POP_FRONT: begin
                            if (is_none) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_front = next_slot;
                                n_count = r_count - CW'(1);
                            end
                        end
                        REQ_POP_BACK: begin
                            if (is_none) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_count = r_count - CW'(1);
                            end
                        end
                        REQ_READ: begin
                            if (is_none) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_dvd  = pos_mag;
                                n_rem  = '0;
                                n_step = '0;
                                n_neg  = pos_raw[POS_W-1];
                            end
                        end
                        REQ_CLEAR: begin
                            n_front = '0;
                            n_count = '0;
                        end
                        default: ;
                    endcase
                    // Reads of a non-empty queue report later
                    n_out_valid = !(req == REQ_READ && !is_none);
                end
            end
            S_DIV: begin
                // Shift in one dividend bit, subtract the count when it fits
                n_rem  = (div_trial >= {1'b0, r_count}) ? CW'(div_trial - {1'b0, r_count})
                                                        : div_trial[CW-1:0];
                n_dvd  = r_dvd << 1;
                n_step = r_step + STEP_W'(1);
            end
            S_IDX: begin
                n_addr = (idx_sum >= DEPTH_S) ? SW'(idx_sum - DEPTH_S) : idx_sum[SW-1:0];
            end
            S_OUT: begin
                if (out_free) begin
                    n_rd_value  = rdata_ext[VAL_W-1:0];
                    n_status    = ST_OK;
                    n_out_valid = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Count and empty flag after the request
    assign cnt_ext     = {{CNT_OUT_W{1'b0}}, n_count};
    assign n_cnt_out   = cnt_ext[CNT_OUT_W-1:0];
    assign n_empty_out = (n_count == '0);

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_front     <= n_front;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Working and payload registers
    always_ff @(posedge i_clk) begin
        r_dvd  <= n_dvd;
        r_rem  <= n_rem;
        r_step <= n_step;
        r_neg  <= n_neg;
        r_addr <= n_addr;
        r_rd_value <= n_rd_value;
        r_status   <= n_status;
        if (n_out_valid && !(r_out_valid && !i_ready)) begin
            r_cnt_out   <= n_cnt_out;
            r_empty_out <= n_empty_out;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_read_value    = r_rd_value;
    assign o_element_count = r_cnt_out;
    assign o_is_empty      = r_empty_out;
    assign o_status        = r_status;

endmodule

// ===== src/deq_ram.sv =====
`timescale 1ns / 1ps

module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port, holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
